// ===== rtl/spit_pkg.sv =====
package spit_pkg;

  localparam int DEFAULT_CAPACITY = 32;
  localparam logic [15:0] MAX_POS = 16'hFFFF;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_FIND   = 2'd2,
    FN_SWAP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] off;
    logic [15:0] len;
    logic        endm;
  } entry_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] position;
    logic [15:0] begin_offset;
    logic [15:0] net_length;
    logic        end_marker;
    logic [15:0] first_item_offset;
    logic [15:0] second_item_offset;
    logic [15:0] items_end_offset;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot_index;
    logic        entry_valid;
    logic [15:0] entry_position;
    logic [15:0] entry_offset;
    logic [15:0] entry_length;
    logic        entry_end_marker;
    logic [5:0]  entry_count;
  } out_item_t;

endpackage

// ===== rtl/spit_ram.sv =====
module spit_ram #(
  parameter int DEPTH = 32,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  spit_pkg::entry_t    wdata,
  input  logic [IDX_W-1:0]    raddr,
  output spit_pkg::entry_t    rdata
);
  import spit_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/spit_ctrl.sv =====
module spit_ctrl #(
  parameter int CAPACITY = 32,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  spit_pkg::in_item_t   cmd,
  output logic                 done,
  output spit_pkg::out_item_t  result,
  output logic                 we,
  output logic [IDX_W-1:0]     waddr,
  output spit_pkg::entry_t     wdata,
  output logic [IDX_W-1:0]     raddr,
  input  spit_pkg::entry_t     rdata
);
  import spit_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_BSRCH   = 7'b0000100,
    S_DECIDE  = 7'b0001000,
    S_SHIFT   = 7'b0010000,
    S_PUT_NEW = 7'b0100000,
    S_SWAP_W2 = 7'b1000000
  } state_t;

  state_t     state, state_next;
  in_item_t   op, op_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] scan_addr, scan_addr_next;
  logic [CNT_W-1:0] bs_lo, bs_lo_next;
  logic [CNT_W-1:0] bs_n, bs_n_next;
  logic       chk_valid, chk_valid_next;
  logic [IDX_W-1:0] chk_idx, chk_idx_next;
  logic [CNT_W-1:0] slot, slot_next;
  logic       hit, hit_next;
  entry_t     x, x_next;
  logic [IDX_W-1:0] sh_addr, sh_addr_next;
  logic [CNT_W-1:0] sh_left, sh_left_next;
  logic       wb_valid, wb_valid_next;
  logic [IDX_W-1:0] wb_addr, wb_addr_next;
  logic       done_next;
  out_item_t  result_next;

  logic [15:0] p, q, len_first, len_second;
  logic       is_insert, full, scan_hit, slot_has_next;
  logic [CNT_W-1:0] bs_half, bs_mid;
  entry_t     x_up, x_down, y_down, new_entry;

  function automatic logic [5:0] to6(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[5:0];
  endfunction

  assign p          = op.position;
  assign q          = op.position + 16'd1;
  assign len_first  = op.second_item_offset - op.first_item_offset;
  assign len_second = op.items_end_offset - op.second_item_offset;
  assign is_insert  = (op.func == FN_ADD);
  assign full       = (count == CNT_W'(CAPACITY));
  assign slot_has_next = ((slot + CNT_W'(1)) < count);
  assign bs_half    = bs_n >> 1;
  assign bs_mid     = bs_lo + bs_half;

  assign x_up      = '{pos: q, off: x.off + len_second, len: x.len, endm: x.endm};
  assign x_down    = '{pos: p, off: x.off - len_first, len: x.len, endm: x.endm};
  assign y_down    = '{pos: p, off: rdata.off - len_first, len: rdata.len, endm: rdata.endm};
  assign new_entry = '{pos: op.position, off: op.begin_offset, len: op.net_length,
                       endm: op.end_marker};

  assign scan_hit = chk_valid && !rdata.endm && (rdata.pos == p || rdata.pos == q);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    op_next        = op;
    count_next     = count;
    scan_addr_next = scan_addr;
    bs_lo_next     = bs_lo;
    bs_n_next      = bs_n;
    chk_valid_next = 1'b0;
    chk_idx_next   = chk_idx;
    slot_next      = slot;
    hit_next       = hit;
    x_next         = x;
    sh_addr_next   = sh_addr;
    sh_left_next   = sh_left;
    wb_valid_next  = 1'b0;
    wb_addr_next   = wb_addr;
    done_next      = 1'b0;
    result_next    = result;
    we             = 1'b0;
    waddr          = slot[IDX_W-1:0];
    wdata          = new_entry;
    raddr          = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next        = cmd;
          scan_addr_next = '0;
          bs_lo_next     = '0;
          bs_n_next      = count;
          state_next     = (cmd.func == FN_SWAP) ? S_SCAN : S_BSRCH;
        end
      end

      S_SCAN: begin
        if (scan_hit) begin
          slot_next  = CNT_W'(chk_idx);
          hit_next   = 1'b1;
          x_next     = rdata;
          raddr      = chk_idx + IDX_W'(1);
          state_next = S_DECIDE;
        end else if (scan_addr >= count) begin
          slot_next  = count;
          hit_next   = 1'b0;
          state_next = S_DECIDE;
        end else begin
          raddr          = scan_addr[IDX_W-1:0];
          chk_idx_next   = scan_addr[IDX_W-1:0];
          chk_valid_next = 1'b1;
          scan_addr_next = scan_addr + CNT_W'(1);
        end
      end

      S_BSRCH: begin
        if (chk_valid) begin
          if (rdata.pos < p) begin
            bs_lo_next = CNT_W'(chk_idx) + CNT_W'(1);
            bs_n_next  = bs_n - bs_half - CNT_W'(1);
          end else begin
            bs_n_next = bs_half;
          end
        end else if (bs_n != '0) begin
          raddr          = bs_mid[IDX_W-1:0];
          chk_idx_next   = bs_mid[IDX_W-1:0];
          chk_valid_next = 1'b1;
        end else begin
          slot_next  = bs_lo;
          hit_next   = (bs_lo < count);
          raddr      = bs_lo[IDX_W-1:0];
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        done_next          = 1'b1;
        state_next         = S_IDLE;
        result_next        = '0;
        result_next.status = ST_DONE;
        result_next.slot_index = to6(slot);
        unique case (op.func)
          FN_FIND: begin
            if (hit) begin
              result_next.status           = (rdata.pos == p) ? ST_DONE : ST_NOTFOUND;
              result_next.entry_valid      = 1'b1;
              result_next.entry_position   = rdata.pos;
              result_next.entry_offset     = rdata.off;
              result_next.entry_length     = rdata.len;
              result_next.entry_end_marker = rdata.endm;
            end else begin
              result_next.status = ST_NOTFOUND;
            end
          end
          FN_ADD: begin
            if (hit && rdata.pos == p) begin
              result_next.status = ST_PRESENT;
            end else if (full) begin
              result_next.status = ST_FULL;
            end else begin
              done_next    = 1'b0;
              sh_left_next = count - slot;
              sh_addr_next = IDX_W'(count - CNT_W'(1));
              state_next   = S_SHIFT;
            end
          end
          FN_REMOVE: begin
            if (!hit || rdata.pos != p) begin
              result_next.status = ST_NOTFOUND;
            end else begin
              done_next    = 1'b0;
              sh_left_next = count - slot - CNT_W'(1);
              sh_addr_next = IDX_W'(slot + CNT_W'(1));
              state_next   = S_SHIFT;
            end
          end
          FN_SWAP: begin
            if (p == MAX_POS || !hit) begin
              result_next.status     = ST_NOTFOUND;
              result_next.slot_index = to6(count);
            end else if (x.pos == q) begin
              we    = 1'b1;
              wdata = x_down;
            end else if (slot_has_next && !rdata.endm && rdata.pos == q) begin
              we         = 1'b1;
              wdata      = y_down;
              done_next  = 1'b0;
              state_next = S_SWAP_W2;
            end else begin
              we    = 1'b1;
              wdata = x_up;
            end
          end
          default: begin
            result_next.status = ST_NOTFOUND;
          end
        endcase
      end

      S_SHIFT: begin
        if (wb_valid) begin
          we    = 1'b1;
          waddr = wb_addr;
          wdata = rdata;
        end
        if (sh_left != '0) begin
          raddr         = sh_addr;
          wb_valid_next = 1'b1;
          sh_left_next  = sh_left - CNT_W'(1);
          if (is_insert) begin
            wb_addr_next = sh_addr + IDX_W'(1);
            sh_addr_next = sh_addr - IDX_W'(1);
          end else begin
            wb_addr_next = sh_addr - IDX_W'(1);
            sh_addr_next = sh_addr + IDX_W'(1);
          end
        end else if (is_insert) begin
          state_next = S_PUT_NEW;
        end else begin
          count_next         = count - CNT_W'(1);
          done_next          = 1'b1;
          state_next         = S_IDLE;
          result_next        = '0;
          result_next.status = ST_DONE;
          result_next.slot_index = to6(slot);
        end
      end

      S_PUT_NEW: begin
        we                 = 1'b1;
        wdata              = new_entry;
        count_next         = count + CNT_W'(1);
        done_next          = 1'b1;
        state_next         = S_IDLE;
        result_next        = '0;
        result_next.status = ST_DONE;
        result_next.slot_index = to6(slot);
      end

      S_SWAP_W2: begin
        we                 = 1'b1;
        waddr              = IDX_W'(slot + CNT_W'(1));
        wdata              = x_up;
        done_next          = 1'b1;
        state_next         = S_IDLE;
        result_next        = '0;
        result_next.status = ST_DONE;
        result_next.slot_index = to6(slot);
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done_next) begin
      result_next.entry_count = to6(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      wb_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      chk_valid <= chk_valid_next;
      wb_valid  <= wb_valid_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    scan_addr <= scan_addr_next;
    bs_lo     <= bs_lo_next;
    bs_n      <= bs_n_next;
    chk_idx   <= chk_idx_next;
    slot      <= slot_next;
    hit       <= hit_next;
    x         <= x_next;
    sh_addr   <= sh_addr_next;
    sh_left   <= sh_left_next;
    wb_addr   <= wb_addr_next;
    result    <= result_next;
  end

endmodule

// ===== rtl/sorted_position_index_table.sv =====
// Channel   Signals              Transfer
// command   start, busy, cmd     rising edge with start high and busy low
// result    done, result         every cycle with done high; never held off
//
// Add, remove and find locate their slot by a binary search through the memory
// read port, each probe issuing a read and then comparing its data, and then
// read the slot. Swap scans the entries in order, one per cycle, until a match
// or the end. A decide state follows; add and remove then move each entry behind
// the slot, add writes the new entry last, and swap rewrites up to two entries.
// Reset clears the entry count and the control state; the table memory is not cleared.
// The result strobe comes in the first idle cycle, and a new command may be
// started in that cycle.
module sorted_position_index_table #(
  parameter int CAPACITY = spit_pkg::DEFAULT_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  spit_pkg::in_item_t   cmd,
  output logic                 done,
  output spit_pkg::out_item_t  result
);
  import spit_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  entry_t           wdata;
  entry_t           rdata;

  spit_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  spit_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_find_only_entry: assert property (@(posedge clk) disable iff (rst)
    (done && result.entry_valid) |-> (result.status == ST_DONE ||
                                      result.status == ST_NOTFOUND))
    else $error("entry fields reported with an add or remove status");
`endif

endmodule
